### design/hed_pkg.sv
// Package for the HTML entity decoder: character codes, character classes,
// and the fixed table of named references. Depends on nothing.
package hed_pkg;

  localparam int CHAR_W = 16;
  localparam int NAME_TBL_LEN = 252;
  localparam int KEY_W = 64;

  localparam logic [CHAR_W-1:0] CH_AMP  = 16'h0026;
  localparam logic [CHAR_W-1:0] CH_HASH = 16'h0023;
  localparam logic [CHAR_W-1:0] CH_X    = 16'h0078;
  localparam logic [CHAR_W-1:0] CH_SEMI = 16'h003B;

  typedef logic [CHAR_W-1:0] char_t;

  // One result word as it waits in the output register.
  typedef struct packed {
    char_t ch;
    logic  last;
    logic  done;
  } out_word_t;

  function automatic logic is_dec(input char_t c);
    return (c >= 16'h30) && (c <= 16'h39);
  endfunction

  function automatic logic is_alnum(input char_t c);
    return is_dec(c) || ((c >= 16'h41) && (c <= 16'h5A)) ||
           ((c >= 16'h61) && (c <= 16'h7A));
  endfunction

  function automatic logic is_hex(input char_t c);
    return is_dec(c) || ((c >= 16'h61) && (c <= 16'h66)) ||
           ((c >= 16'h41) && (c <= 16'h46));
  endfunction

  function automatic logic [3:0] hex_val(input char_t c);
    logic [3:0] v;
    if (is_dec(c)) v = c[3:0];
    else v = c[3:0] + 4'd9;
    return v;
  endfunction

  // Name key: eight ASCII bytes, first character in the high byte, zero padded.
  function automatic logic [KEY_W-1:0] key_of(input string s);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < s.len()) k[KEY_W-1-8*i -: 8] = s[i];
    end
    return k;
  endfunction

  // Return the code of a name key, or found = 0.
  function automatic logic [16:0] name_lookup(input logic [KEY_W-1:0] k);
    logic [16:0] r;
    r = '0;
    case (k)
      key_of("nbsp"): r = {1'b1, 16'h00A0};
      key_of("iexcl"): r = {1'b1, 16'h00A1};
      key_of("cent"): r = {1'b1, 16'h00A2};
      key_of("pound"): r = {1'b1, 16'h00A3};
      key_of("curren"): r = {1'b1, 16'h00A4};
      key_of("yen"): r = {1'b1, 16'h00A5};
      key_of("brvbar"): r = {1'b1, 16'h00A6};
      key_of("sect"): r = {1'b1, 16'h00A7};
      key_of("uml"): r = {1'b1, 16'h00A8};
      key_of("copy"): r = {1'b1, 16'h00A9};
      key_of("ordf"): r = {1'b1, 16'h00AA};
      key_of("laquo"): r = {1'b1, 16'h00AB};
      key_of("not"): r = {1'b1, 16'h00AC};
      key_of("shy"): r = {1'b1, 16'h00AD};
      key_of("reg"): r = {1'b1, 16'h00AE};
      key_of("macr"): r = {1'b1, 16'h00AF};
      key_of("deg"): r = {1'b1, 16'h00B0};
      key_of("plusmn"): r = {1'b1, 16'h00B1};
      key_of("sup2"): r = {1'b1, 16'h00B2};
      key_of("sup3"): r = {1'b1, 16'h00B3};
      key_of("acute"): r = {1'b1, 16'h00B4};
      key_of("micro"): r = {1'b1, 16'h00B5};
      key_of("para"): r = {1'b1, 16'h00B6};
      key_of("middot"): r = {1'b1, 16'h00B7};
      key_of("cedil"): r = {1'b1, 16'h00B8};
      key_of("sup1"): r = {1'b1, 16'h00B9};
      key_of("ordm"): r = {1'b1, 16'h00BA};
      key_of("raquo"): r = {1'b1, 16'h00BB};
      key_of("frac14"): r = {1'b1, 16'h00BC};
      key_of("frac12"): r = {1'b1, 16'h00BD};
      key_of("frac34"): r = {1'b1, 16'h00BE};
      key_of("iquest"): r = {1'b1, 16'h00BF};
      key_of("Agrave"): r = {1'b1, 16'h00C0};
      key_of("Aacute"): r = {1'b1, 16'h00C1};
      key_of("Acirc"): r = {1'b1, 16'h00C2};
      key_of("Atilde"): r = {1'b1, 16'h00C3};
      key_of("Auml"): r = {1'b1, 16'h00C4};
      key_of("Aring"): r = {1'b1, 16'h00C5};
      key_of("AElig"): r = {1'b1, 16'h00C6};
      key_of("Ccedil"): r = {1'b1, 16'h00C7};
      key_of("Egrave"): r = {1'b1, 16'h00C8};
      key_of("Eacute"): r = {1'b1, 16'h00C9};
      key_of("Ecirc"): r = {1'b1, 16'h00CA};
      key_of("Euml"): r = {1'b1, 16'h00CB};
      key_of("Igrave"): r = {1'b1, 16'h00CC};
      key_of("Iacute"): r = {1'b1, 16'h00CD};
      key_of("Icirc"): r = {1'b1, 16'h00CE};
      key_of("Iuml"): r = {1'b1, 16'h00CF};
      key_of("ETH"): r = {1'b1, 16'h00D0};
      key_of("Ntilde"): r = {1'b1, 16'h00D1};
      key_of("Ograve"): r = {1'b1, 16'h00D2};
      key_of("Oacute"): r = {1'b1, 16'h00D3};
      key_of("Ocirc"): r = {1'b1, 16'h00D4};
      key_of("Otilde"): r = {1'b1, 16'h00D5};
      key_of("Ouml"): r = {1'b1, 16'h00D6};
      key_of("times"): r = {1'b1, 16'h00D7};
      key_of("Oslash"): r = {1'b1, 16'h00D8};
      key_of("Ugrave"): r = {1'b1, 16'h00D9};
      key_of("Uacute"): r = {1'b1, 16'h00DA};
      key_of("Ucirc"): r = {1'b1, 16'h00DB};
      key_of("Uuml"): r = {1'b1, 16'h00DC};
      key_of("Yacute"): r = {1'b1, 16'h00DD};
      key_of("THORN"): r = {1'b1, 16'h00DE};
      key_of("szlig"): r = {1'b1, 16'h00DF};
      key_of("agrave"): r = {1'b1, 16'h00E0};
      key_of("aacute"): r = {1'b1, 16'h00E1};
      key_of("acirc"): r = {1'b1, 16'h00E2};
      key_of("atilde"): r = {1'b1, 16'h00E3};
      key_of("auml"): r = {1'b1, 16'h00E4};
      key_of("aring"): r = {1'b1, 16'h00E5};
      key_of("aelig"): r = {1'b1, 16'h00E6};
      key_of("ccedil"): r = {1'b1, 16'h00E7};
      key_of("egrave"): r = {1'b1, 16'h00E8};
      key_of("eacute"): r = {1'b1, 16'h00E9};
      key_of("ecirc"): r = {1'b1, 16'h00EA};
      key_of("euml"): r = {1'b1, 16'h00EB};
      key_of("igrave"): r = {1'b1, 16'h00EC};
      key_of("iacute"): r = {1'b1, 16'h00ED};
      key_of("icirc"): r = {1'b1, 16'h00EE};
      key_of("iuml"): r = {1'b1, 16'h00EF};
      key_of("eth"): r = {1'b1, 16'h00F0};
      key_of("ntilde"): r = {1'b1, 16'h00F1};
      key_of("ograve"): r = {1'b1, 16'h00F2};
      key_of("oacute"): r = {1'b1, 16'h00F3};
      key_of("ocirc"): r = {1'b1, 16'h00F4};
      key_of("otilde"): r = {1'b1, 16'h00F5};
      key_of("ouml"): r = {1'b1, 16'h00F6};
      key_of("divide"): r = {1'b1, 16'h00F7};
      key_of("oslash"): r = {1'b1, 16'h00F8};
      key_of("ugrave"): r = {1'b1, 16'h00F9};
      key_of("uacute"): r = {1'b1, 16'h00FA};
      key_of("ucirc"): r = {1'b1, 16'h00FB};
      key_of("uuml"): r = {1'b1, 16'h00FC};
      key_of("yacute"): r = {1'b1, 16'h00FD};
      key_of("thorn"): r = {1'b1, 16'h00FE};
      key_of("yuml"): r = {1'b1, 16'h00FF};
      key_of("fnof"): r = {1'b1, 16'h0192};
      key_of("Alpha"): r = {1'b1, 16'h0391};
      key_of("Beta"): r = {1'b1, 16'h0392};
      key_of("Gamma"): r = {1'b1, 16'h0393};
      key_of("Delta"): r = {1'b1, 16'h0394};
      key_of("Epsilon"): r = {1'b1, 16'h0395};
      key_of("Zeta"): r = {1'b1, 16'h0396};
      key_of("Eta"): r = {1'b1, 16'h0397};
      key_of("Theta"): r = {1'b1, 16'h0398};
      key_of("Iota"): r = {1'b1, 16'h0399};
      key_of("Kappa"): r = {1'b1, 16'h039A};
      key_of("Lambda"): r = {1'b1, 16'h039B};
      key_of("Mu"): r = {1'b1, 16'h039C};
      key_of("Nu"): r = {1'b1, 16'h039D};
      key_of("Xi"): r = {1'b1, 16'h039E};
      key_of("Omicron"): r = {1'b1, 16'h039F};
      key_of("Pi"): r = {1'b1, 16'h03A0};
      key_of("Rho"): r = {1'b1, 16'h03A1};
      key_of("Sigma"): r = {1'b1, 16'h03A3};
      key_of("Tau"): r = {1'b1, 16'h03A4};
      key_of("Upsilon"): r = {1'b1, 16'h03A5};
      key_of("Phi"): r = {1'b1, 16'h03A6};
      key_of("Chi"): r = {1'b1, 16'h03A7};
      key_of("Psi"): r = {1'b1, 16'h03A8};
      key_of("Omega"): r = {1'b1, 16'h03A9};
      key_of("alpha"): r = {1'b1, 16'h03B1};
      key_of("beta"): r = {1'b1, 16'h03B2};
      key_of("gamma"): r = {1'b1, 16'h03B3};
      key_of("delta"): r = {1'b1, 16'h03B4};
      key_of("epsilon"): r = {1'b1, 16'h03B5};
      key_of("zeta"): r = {1'b1, 16'h03B6};
      key_of("eta"): r = {1'b1, 16'h03B7};
      key_of("theta"): r = {1'b1, 16'h03B8};
      key_of("iota"): r = {1'b1, 16'h03B9};
      key_of("kappa"): r = {1'b1, 16'h03BA};
      key_of("lambda"): r = {1'b1, 16'h03BB};
      key_of("mu"): r = {1'b1, 16'h03BC};
      key_of("nu"): r = {1'b1, 16'h03BD};
      key_of("xi"): r = {1'b1, 16'h03BE};
      key_of("omicron"): r = {1'b1, 16'h03BF};
      key_of("pi"): r = {1'b1, 16'h03C0};
      key_of("rho"): r = {1'b1, 16'h03C1};
      key_of("sigmaf"): r = {1'b1, 16'h03C2};
      key_of("sigma"): r = {1'b1, 16'h03C3};
      key_of("tau"): r = {1'b1, 16'h03C4};
      key_of("upsilon"): r = {1'b1, 16'h03C5};
      key_of("phi"): r = {1'b1, 16'h03C6};
      key_of("chi"): r = {1'b1, 16'h03C7};
      key_of("psi"): r = {1'b1, 16'h03C8};
      key_of("omega"): r = {1'b1, 16'h03C9};
      key_of("thetasym"): r = {1'b1, 16'h03D1};
      key_of("upsih"): r = {1'b1, 16'h03D2};
      key_of("piv"): r = {1'b1, 16'h03D6};
      key_of("bull"): r = {1'b1, 16'h2022};
      key_of("hellip"): r = {1'b1, 16'h2026};
      key_of("prime"): r = {1'b1, 16'h2032};
      key_of("Prime"): r = {1'b1, 16'h2033};
      key_of("oline"): r = {1'b1, 16'h203E};
      key_of("frasl"): r = {1'b1, 16'h2044};
      key_of("weierp"): r = {1'b1, 16'h2118};
      key_of("image"): r = {1'b1, 16'h2111};
      key_of("real"): r = {1'b1, 16'h211C};
      key_of("trade"): r = {1'b1, 16'h2122};
      key_of("alefsym"): r = {1'b1, 16'h2135};
      key_of("larr"): r = {1'b1, 16'h2190};
      key_of("uarr"): r = {1'b1, 16'h2191};
      key_of("rarr"): r = {1'b1, 16'h2192};
      key_of("darr"): r = {1'b1, 16'h2193};
      key_of("harr"): r = {1'b1, 16'h2194};
      key_of("crarr"): r = {1'b1, 16'h21B5};
      key_of("lArr"): r = {1'b1, 16'h21D0};
      key_of("uArr"): r = {1'b1, 16'h21D1};
      key_of("rArr"): r = {1'b1, 16'h21D2};
      key_of("dArr"): r = {1'b1, 16'h21D3};
      key_of("hArr"): r = {1'b1, 16'h21D4};
      key_of("forall"): r = {1'b1, 16'h2200};
      key_of("part"): r = {1'b1, 16'h2202};
      key_of("exist"): r = {1'b1, 16'h2203};
      key_of("empty"): r = {1'b1, 16'h2205};
      key_of("nabla"): r = {1'b1, 16'h2207};
      key_of("isin"): r = {1'b1, 16'h2208};
      key_of("notin"): r = {1'b1, 16'h2209};
      key_of("ni"): r = {1'b1, 16'h220B};
      key_of("prod"): r = {1'b1, 16'h220F};
      key_of("sum"): r = {1'b1, 16'h2211};
      key_of("minus"): r = {1'b1, 16'h2212};
      key_of("lowast"): r = {1'b1, 16'h2217};
      key_of("radic"): r = {1'b1, 16'h221A};
      key_of("prop"): r = {1'b1, 16'h221D};
      key_of("infin"): r = {1'b1, 16'h221E};
      key_of("ang"): r = {1'b1, 16'h2220};
      key_of("and"): r = {1'b1, 16'h2227};
      key_of("or"): r = {1'b1, 16'h2228};
      key_of("cap"): r = {1'b1, 16'h2229};
      key_of("cup"): r = {1'b1, 16'h222A};
      key_of("int"): r = {1'b1, 16'h222B};
      key_of("there4"): r = {1'b1, 16'h2234};
      key_of("sim"): r = {1'b1, 16'h223C};
      key_of("cong"): r = {1'b1, 16'h2245};
      key_of("asymp"): r = {1'b1, 16'h2248};
      key_of("ne"): r = {1'b1, 16'h2260};
      key_of("equiv"): r = {1'b1, 16'h2261};
      key_of("le"): r = {1'b1, 16'h2264};
      key_of("ge"): r = {1'b1, 16'h2265};
      key_of("sub"): r = {1'b1, 16'h2282};
      key_of("sup"): r = {1'b1, 16'h2283};
      key_of("nsub"): r = {1'b1, 16'h2284};
      key_of("sube"): r = {1'b1, 16'h2286};
      key_of("supe"): r = {1'b1, 16'h2287};
      key_of("oplus"): r = {1'b1, 16'h2295};
      key_of("otimes"): r = {1'b1, 16'h2297};
      key_of("perp"): r = {1'b1, 16'h22A5};
      key_of("sdot"): r = {1'b1, 16'h22C5};
      key_of("lceil"): r = {1'b1, 16'h2308};
      key_of("rceil"): r = {1'b1, 16'h2309};
      key_of("lfloor"): r = {1'b1, 16'h230A};
      key_of("rfloor"): r = {1'b1, 16'h230B};
      key_of("lang"): r = {1'b1, 16'h2329};
      key_of("rang"): r = {1'b1, 16'h232A};
      key_of("loz"): r = {1'b1, 16'h25CA};
      key_of("spades"): r = {1'b1, 16'h2660};
      key_of("clubs"): r = {1'b1, 16'h2663};
      key_of("hearts"): r = {1'b1, 16'h2665};
      key_of("diams"): r = {1'b1, 16'h2666};
      key_of("quot"): r = {1'b1, 16'h0022};
      key_of("amp"): r = {1'b1, 16'h0026};
      key_of("lt"): r = {1'b1, 16'h003C};
      key_of("gt"): r = {1'b1, 16'h003E};
      key_of("OElig"): r = {1'b1, 16'h0152};
      key_of("oelig"): r = {1'b1, 16'h0153};
      key_of("Scaron"): r = {1'b1, 16'h0160};
      key_of("scaron"): r = {1'b1, 16'h0161};
      key_of("Yuml"): r = {1'b1, 16'h0178};
      key_of("circ"): r = {1'b1, 16'h02C6};
      key_of("tilde"): r = {1'b1, 16'h02DC};
      key_of("ensp"): r = {1'b1, 16'h2002};
      key_of("emsp"): r = {1'b1, 16'h2003};
      key_of("thinsp"): r = {1'b1, 16'h2009};
      key_of("zwnj"): r = {1'b1, 16'h200C};
      key_of("zwj"): r = {1'b1, 16'h200D};
      key_of("lrm"): r = {1'b1, 16'h200E};
      key_of("rlm"): r = {1'b1, 16'h200F};
      key_of("ndash"): r = {1'b1, 16'h2013};
      key_of("mdash"): r = {1'b1, 16'h2014};
      key_of("lsquo"): r = {1'b1, 16'h2018};
      key_of("rsquo"): r = {1'b1, 16'h2019};
      key_of("sbquo"): r = {1'b1, 16'h201A};
      key_of("ldquo"): r = {1'b1, 16'h201C};
      key_of("rdquo"): r = {1'b1, 16'h201D};
      key_of("bdquo"): r = {1'b1, 16'h201E};
      key_of("dagger"): r = {1'b1, 16'h2020};
      key_of("Dagger"): r = {1'b1, 16'h2021};
      key_of("permil"): r = {1'b1, 16'h2030};
      key_of("lsaquo"): r = {1'b1, 16'h2039};
      key_of("rsaquo"): r = {1'b1, 16'h203A};
      key_of("euro"): r = {1'b1, 16'h20AC};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### design/hed_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module hed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

### design/html_entity_decoder.sv
// HTML entity decoder top level: parser, hold buffer RAM and output register.
// Depends on hed_pkg and hed_ram.
//
//  channel | ports                              | direction
//  input   | in_valid in_ready in_char in_text_end      | in
//  result  | out_valid out_ready out_char out_run_last out_text_done | out
//
// An input word that emits at most one word is parsed without a replay.
// A failed run replays the held words from the hold RAM one per cycle while
// the output is free; the first read is issued by the failing input itself, so
// no bubble is added. The word that ended the run follows the replay, unless an
// '&' restarts a candidate; an end of text flushes the held words
// after its own result. Input is stalled while a replay runs or the output
// register is full and not being drained. Reset (rst_n low, synchronous)
// returns the parser to idle with an empty buffer; the RAM needs no reset.
module html_entity_decoder #(
  parameter int MIN_NAME_LEN = 2,
  parameter int MAX_NAME_LEN = 8,
  parameter int MAX_DIGITS   = 8,
  parameter int CHAR_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_char,
  input  logic        in_text_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_char,
  output logic        out_run_last,
  output logic        out_text_done
);

  localparam int HOLD_DEPTH = ((3 + MAX_DIGITS) > (1 + MAX_NAME_LEN)) ?
                              (3 + MAX_DIGITS) : (1 + MAX_NAME_LEN);
  localparam int AW = $clog2(HOLD_DEPTH);
  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam logic [31:0] CMASK = (CHAR_BITS >= 32) ? 32'hFFFF_FFFF :
                                  ((32'd1 << CHAR_BITS) - 32'd1);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_AMP  = 3'd1;
  localparam logic [2:0] PH_HASH = 3'd2;
  localparam logic [2:0] PH_HEX  = 3'd3;
  localparam logic [2:0] PH_DEC  = 3'd4;
  localparam logic [2:0] PH_NAME = 3'd5;
  localparam logic [2:0] PH_FLSH = 3'd6;

  logic [2:0]    phase_r, phase_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   num_r, num_nxt;
  logic [hed_pkg::KEY_W-1:0] key_r, key_nxt;

  // Replay bookkeeping
  logic [CW-1:0] fl_n_r, fl_n_nxt;
  logic [CW-1:0] fl_rd_r, fl_rd_nxt;
  logic          fl_rv_r, fl_rv_nxt;
  hed_pkg::char_t fl_tail_r, fl_tail_nxt;
  logic          fl_tail_v_r, fl_tail_v_nxt;
  logic          fl_end_r, fl_end_nxt;
  logic [2:0]    fl_ph_r, fl_ph_nxt;
  logic [CW-1:0] fl_cnt_r, fl_cnt_nxt;

  hed_pkg::out_word_t ob_r, ob_nxt;
  logic               ob_v_r, ob_v_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  hed_pkg::char_t wr_data;
  hed_pkg::char_t rd_data;

  hed_ram #(.WIDTH(16), .DEPTH(HOLD_DEPTH)) u_hold (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  logic ob_free;
  assign ob_free  = !ob_v_r || out_ready;
  assign in_ready = (phase_r != PH_FLSH) && ob_free;
  assign out_valid     = ob_v_r;
  assign out_char      = ob_r.ch;
  assign out_run_last  = ob_r.last;
  assign out_text_done = ob_r.done;

  logic acc;
  assign acc = in_valid && in_ready;

  // Parse one input word and schedule its results, or step the replay
  always_comb begin
    logic fail, hold, emit_c, fin;
    logic [31:0] fval;
    logic [CW-1:0] digs;
    logic [16:0] lk;
    logic [2:0] nph;
    logic [CW-1:0] ncnt;
    logic [CW-1:0] base;
    phase_nxt = phase_r; cnt_nxt = cnt_r; num_nxt = num_r; key_nxt = key_r;
    fl_n_nxt = fl_n_r; fl_rd_nxt = fl_rd_r; fl_rv_nxt = 1'b0;
    fl_tail_nxt = fl_tail_r; fl_tail_v_nxt = fl_tail_v_r; fl_end_nxt = fl_end_r;
    fl_ph_nxt = fl_ph_r; fl_cnt_nxt = fl_cnt_r;
    ob_nxt = ob_r; ob_v_nxt = ob_v_r && !out_ready;
    wr_en = 1'b0; wr_addr = cnt_r[AW-1:0]; rd_addr = fl_rd_r[AW-1:0];
    wr_data = in_char;
    fail = 1'b0; hold = 1'b0; emit_c = 1'b0; fin = 1'b0; fval = '0;
    lk = hed_pkg::name_lookup(key_r);
    nph = phase_r; ncnt = cnt_r; digs = '0; base = '0;
    if (acc) begin
      unique case (phase_r)
        PH_AMP: begin
          if (in_char == hed_pkg::CH_HASH) begin hold = 1'b1; nph = PH_HASH; end
          else if (hed_pkg::is_alnum(in_char)) begin hold = 1'b1; nph = PH_NAME; end
          else fail = 1'b1;
        end
        PH_HASH: begin
          if (in_char == hed_pkg::CH_X) begin
            hold = 1'b1; num_nxt = '0; nph = PH_HEX;
          end else if (hed_pkg::is_dec(in_char)) begin
            hold = 1'b1; num_nxt = {28'd0, in_char[3:0]}; nph = PH_DEC;
          end else fail = 1'b1;
        end
        PH_HEX, PH_DEC: begin
          base = (phase_r == PH_HEX) ? CW'(3) : CW'(2);
          digs = (cnt_r >= base) ? cnt_r - base : '0;
          if ((phase_r == PH_HEX) ? hed_pkg::is_hex(in_char) : hed_pkg::is_dec(in_char)) begin
            if (digs < CW'(MAX_DIGITS)) begin
              hold = 1'b1;
              if (phase_r == PH_HEX)
                num_nxt = {num_r[27:0], hed_pkg::hex_val(in_char)};
              else
                num_nxt = {num_r[28:0], 3'd0} + {num_r[30:0], 1'b0} +
                          {28'd0, in_char[3:0]};
            end else fail = 1'b1;
          end else if (in_char == hed_pkg::CH_SEMI && digs != '0) begin
            fin = 1'b1; fval = num_r & CMASK;
          end else fail = 1'b1;
        end
        PH_NAME: begin
          digs = cnt_r - CW'(1);
          if (hed_pkg::is_alnum(in_char)) begin
            if (digs < CW'(MAX_NAME_LEN)) hold = 1'b1;
            else fail = 1'b1;
          end else if (in_char == hed_pkg::CH_SEMI && digs >= CW'(MIN_NAME_LEN) &&
                       digs <= CW'(8) && lk[16]) begin
            fin = 1'b1; fval = {16'd0, lk[15:0]};
          end else fail = 1'b1;
        end
        default: begin
          if (in_char == hed_pkg::CH_AMP) begin
            ncnt = '0; hold = 1'b1; nph = PH_AMP; key_nxt = '0;
          end else begin
            ncnt = '0; emit_c = 1'b1; nph = PH_IDLE;
          end
        end
      endcase
      if (hold) begin
        wr_en = 1'b1; wr_addr = ncnt[AW-1:0];
        if (ncnt >= CW'(1) && ncnt <= CW'(8))
          key_nxt[hed_pkg::KEY_W-1-8*(int'(ncnt)-1) -: 8] = in_char[7:0];
        ncnt = ncnt + CW'(1);
      end
      if (fin) begin ncnt = '0; nph = PH_IDLE; end
      if (fail) begin
        fl_n_nxt = cnt_r; fl_rd_nxt = '0; fl_rv_nxt = 1'b1;
        if (in_char == hed_pkg::CH_AMP) begin
          fl_tail_v_nxt = 1'b0; wr_en = 1'b0;
          fl_ph_nxt = PH_AMP; fl_cnt_nxt = CW'(1);
        end else begin
          fl_tail_v_nxt = 1'b1; fl_ph_nxt = PH_IDLE; fl_cnt_nxt = '0;
        end
        fl_tail_nxt = in_char;
        rd_addr = '0;
      end
      if (in_text_end && !fail) begin
        if (ncnt == CW'(1)) begin
          // a lone '&' ends the text: pass it straight out
          emit_c = 1'b1;
        end else if (ncnt != '0) begin
          // flush whatever is held after this word's own result
          fail = 1'b1;
          fl_n_nxt = ncnt; fl_rd_nxt = '0; fl_rv_nxt = 1'b1; rd_addr = '0;
          fl_tail_v_nxt = 1'b0; fl_ph_nxt = PH_IDLE; fl_cnt_nxt = '0;
          fl_tail_nxt = fval[15:0];
          if (fin || emit_c) begin
            ob_nxt = '{ch: fin ? fval[15:0] : in_char, last: 1'b0, done: 1'b0};
            ob_v_nxt = 1'b1;
            emit_c = 1'b0; fin = 1'b0;
          end
        end
        nph = PH_IDLE; ncnt = '0; num_nxt = '0;
      end else if (fail && in_text_end) begin
        fl_ph_nxt = PH_IDLE; fl_cnt_nxt = '0; num_nxt = '0;
        if (in_char == hed_pkg::CH_AMP) begin
          // the new candidate '&' is flushed too, as a last word
          fl_tail_v_nxt = 1'b1;
        end
      end
      fl_end_nxt = in_text_end;
      if (fail) begin
        phase_nxt = PH_FLSH; cnt_nxt = ncnt;
        if (in_char == hed_pkg::CH_AMP && !in_text_end) key_nxt = '0;
      end else begin
        phase_nxt = nph; cnt_nxt = ncnt;
        if (fin || emit_c) begin
          ob_nxt = '{ch: fin ? fval[15:0] : in_char, last: 1'b1, done: in_text_end};
          ob_v_nxt = 1'b1;
        end
      end
    end else if (phase_r == PH_FLSH && ob_free) begin
      // replay held words, then the word that ended the run
      if (fl_rv_r && fl_rd_r < fl_n_r) begin
        ob_nxt = '{ch: rd_data,
                   last: (fl_rd_r + CW'(1) == fl_n_r) && !fl_tail_v_r,
                   done: (fl_rd_r + CW'(1) == fl_n_r) && !fl_tail_v_r && fl_end_r};
        ob_v_nxt = 1'b1;
        fl_rd_nxt = fl_rd_r + CW'(1);
        rd_addr = fl_rd_nxt[AW-1:0];
        fl_rv_nxt = 1'b1;
        if ((fl_rd_r + CW'(1) == fl_n_r) && !fl_tail_v_r) begin
          phase_nxt = fl_ph_r; cnt_nxt = fl_cnt_r;
          // restart the candidate with the '&' that ended the run
          if (fl_ph_r == PH_AMP) wr_en = 1'b1;
          wr_addr = '0;
          wr_data = hed_pkg::CH_AMP;
        end
      end else if (fl_rv_r && fl_tail_v_r) begin
        ob_nxt = '{ch: fl_tail_r, last: 1'b1, done: fl_end_r};
        ob_v_nxt = 1'b1;
        phase_nxt = fl_ph_r; cnt_nxt = fl_cnt_r;
      end else begin
        fl_rv_nxt = 1'b1;
      end
    end else if (phase_r == PH_FLSH) begin
      fl_rv_nxt = fl_rv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      num_r   <= '0;
      ob_v_r  <= 1'b0;
      fl_rv_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      num_r   <= num_nxt;
      ob_v_r  <= ob_v_nxt;
      fl_rv_r <= fl_rv_nxt;
    end
    key_r <= key_nxt; ob_r <= ob_nxt;
    fl_n_r <= fl_n_nxt; fl_rd_r <= fl_rd_nxt; fl_tail_r <= fl_tail_nxt;
    fl_tail_v_r <= fl_tail_v_nxt; fl_end_r <= fl_end_nxt;
    fl_ph_r <= fl_ph_nxt; fl_cnt_r <= fl_cnt_nxt;
  end

`ifndef SYNTHESIS
  a_no_in_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FLSH |-> !in_ready) else $error("input taken during replay");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(HOLD_DEPTH)) else $error("hold count overflow");
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> cnt_r == '0) else $error("idle with held words");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char))
    else $error("output word dropped");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for html_entity_decoder: a directed table of texts and
// random reference sequences, checked word by word against a local decoder model.
// Depends on hed_pkg and the decoder RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef hed_pkg::char_t char_t;

  localparam int HELD_MAX = 11;
  localparam int NUM_DIGITS_MAX = 8;
  localparam int NAME_MIN = 2;
  localparam int NAME_MAX = 8;
  localparam int ITEM_GOAL = 320;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 30;

  typedef enum logic [2:0] {PS_IDLE, PS_AMP, PS_HASH, PS_HEX, PS_DEC, PS_NAME} parse_e;

  typedef struct {
    char_t ch;
    logic  last;
    logic  done;
  } word_t;

  typedef struct {
    char_t ch;
    logic  fin;
    bit    typed;
    char_t want;
  } stim_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  char_t in_char = '0;
  logic  in_text_end = 1'b0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  char_t out_char;
  logic  out_run_last;
  logic  out_text_done;

  // decoder model state
  parse_e      phase;
  char_t       held [HELD_MAX];
  int          held_cnt;
  logic [31:0] num_val;

  char_t       entity_code [string];
  string       entity_names [$];
  word_t       pending_words [$];
  stim_t       stim_q [$];
  int          errs = 0;
  int          words_seen = 0;
  int          texts_seen = 0;
  int          directed_len;
  bit          hold_req = 0;
  bit          timed_out = 0;

  html_entity_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_char(in_char),
    .in_text_end(in_text_end),
    .out_valid(out_valid), .out_ready(out_ready), .out_char(out_char),
    .out_run_last(out_run_last), .out_text_done(out_text_done)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void add_name(string s, char_t code);
    entity_code[s] = code;
    entity_names.push_back(s);
  endfunction

  function automatic void load_names();
    add_name("nbsp",16'h00A0); add_name("iexcl",16'h00A1); add_name("cent",16'h00A2);
    add_name("pound",16'h00A3); add_name("curren",16'h00A4); add_name("yen",16'h00A5);
    add_name("brvbar",16'h00A6); add_name("sect",16'h00A7); add_name("uml",16'h00A8);
    add_name("copy",16'h00A9); add_name("ordf",16'h00AA); add_name("laquo",16'h00AB);
    add_name("not",16'h00AC); add_name("shy",16'h00AD); add_name("reg",16'h00AE);
    add_name("macr",16'h00AF); add_name("deg",16'h00B0); add_name("plusmn",16'h00B1);
    add_name("sup2",16'h00B2); add_name("sup3",16'h00B3); add_name("acute",16'h00B4);
    add_name("micro",16'h00B5); add_name("para",16'h00B6); add_name("middot",16'h00B7);
    add_name("cedil",16'h00B8); add_name("sup1",16'h00B9); add_name("ordm",16'h00BA);
    add_name("raquo",16'h00BB); add_name("frac14",16'h00BC); add_name("frac12",16'h00BD);
    add_name("frac34",16'h00BE); add_name("iquest",16'h00BF); add_name("Agrave",16'h00C0);
    add_name("Aacute",16'h00C1); add_name("Acirc",16'h00C2); add_name("Atilde",16'h00C3);
    add_name("Auml",16'h00C4); add_name("Aring",16'h00C5); add_name("AElig",16'h00C6);
    add_name("Ccedil",16'h00C7); add_name("Egrave",16'h00C8); add_name("Eacute",16'h00C9);
    add_name("Ecirc",16'h00CA); add_name("Euml",16'h00CB); add_name("Igrave",16'h00CC);
    add_name("Iacute",16'h00CD); add_name("Icirc",16'h00CE); add_name("Iuml",16'h00CF);
    add_name("ETH",16'h00D0); add_name("Ntilde",16'h00D1); add_name("Ograve",16'h00D2);
    add_name("Oacute",16'h00D3); add_name("Ocirc",16'h00D4); add_name("Otilde",16'h00D5);
    add_name("Ouml",16'h00D6); add_name("times",16'h00D7); add_name("Oslash",16'h00D8);
    add_name("Ugrave",16'h00D9); add_name("Uacute",16'h00DA); add_name("Ucirc",16'h00DB);
    add_name("Uuml",16'h00DC); add_name("Yacute",16'h00DD); add_name("THORN",16'h00DE);
    add_name("szlig",16'h00DF); add_name("agrave",16'h00E0); add_name("aacute",16'h00E1);
    add_name("acirc",16'h00E2); add_name("atilde",16'h00E3); add_name("auml",16'h00E4);
    add_name("aring",16'h00E5); add_name("aelig",16'h00E6); add_name("ccedil",16'h00E7);
    add_name("egrave",16'h00E8); add_name("eacute",16'h00E9); add_name("ecirc",16'h00EA);
    add_name("euml",16'h00EB); add_name("igrave",16'h00EC); add_name("iacute",16'h00ED);
    add_name("icirc",16'h00EE); add_name("iuml",16'h00EF); add_name("eth",16'h00F0);
    add_name("ntilde",16'h00F1); add_name("ograve",16'h00F2); add_name("oacute",16'h00F3);
    add_name("ocirc",16'h00F4); add_name("otilde",16'h00F5); add_name("ouml",16'h00F6);
    add_name("divide",16'h00F7); add_name("oslash",16'h00F8); add_name("ugrave",16'h00F9);
    add_name("uacute",16'h00FA); add_name("ucirc",16'h00FB); add_name("uuml",16'h00FC);
    add_name("yacute",16'h00FD); add_name("thorn",16'h00FE); add_name("yuml",16'h00FF);
    add_name("fnof",16'h0192); add_name("Alpha",16'h0391); add_name("Beta",16'h0392);
    add_name("Gamma",16'h0393); add_name("Delta",16'h0394); add_name("Epsilon",16'h0395);
    add_name("Zeta",16'h0396); add_name("Eta",16'h0397); add_name("Theta",16'h0398);
    add_name("Iota",16'h0399); add_name("Kappa",16'h039A); add_name("Lambda",16'h039B);
    add_name("Mu",16'h039C); add_name("Nu",16'h039D); add_name("Xi",16'h039E);
    add_name("Omicron",16'h039F); add_name("Pi",16'h03A0); add_name("Rho",16'h03A1);
    add_name("Sigma",16'h03A3); add_name("Tau",16'h03A4); add_name("Upsilon",16'h03A5);
    add_name("Phi",16'h03A6); add_name("Chi",16'h03A7); add_name("Psi",16'h03A8);
    add_name("Omega",16'h03A9); add_name("alpha",16'h03B1); add_name("beta",16'h03B2);
    add_name("gamma",16'h03B3); add_name("delta",16'h03B4); add_name("epsilon",16'h03B5);
    add_name("zeta",16'h03B6); add_name("eta",16'h03B7); add_name("theta",16'h03B8);
    add_name("iota",16'h03B9); add_name("kappa",16'h03BA); add_name("lambda",16'h03BB);
    add_name("mu",16'h03BC); add_name("nu",16'h03BD); add_name("xi",16'h03BE);
    add_name("omicron",16'h03BF); add_name("pi",16'h03C0); add_name("rho",16'h03C1);
    add_name("sigmaf",16'h03C2); add_name("sigma",16'h03C3); add_name("tau",16'h03C4);
    add_name("upsilon",16'h03C5); add_name("phi",16'h03C6); add_name("chi",16'h03C7);
    add_name("psi",16'h03C8); add_name("omega",16'h03C9); add_name("thetasym",16'h03D1);
    add_name("upsih",16'h03D2); add_name("piv",16'h03D6); add_name("bull",16'h2022);
    add_name("hellip",16'h2026); add_name("prime",16'h2032); add_name("Prime",16'h2033);
    add_name("oline",16'h203E); add_name("frasl",16'h2044); add_name("weierp",16'h2118);
    add_name("image",16'h2111); add_name("real",16'h211C); add_name("trade",16'h2122);
    add_name("alefsym",16'h2135); add_name("larr",16'h2190); add_name("uarr",16'h2191);
    add_name("rarr",16'h2192); add_name("darr",16'h2193); add_name("harr",16'h2194);
    add_name("crarr",16'h21B5); add_name("lArr",16'h21D0); add_name("uArr",16'h21D1);
    add_name("rArr",16'h21D2); add_name("dArr",16'h21D3); add_name("hArr",16'h21D4);
    add_name("forall",16'h2200); add_name("part",16'h2202); add_name("exist",16'h2203);
    add_name("empty",16'h2205); add_name("nabla",16'h2207); add_name("isin",16'h2208);
    add_name("notin",16'h2209); add_name("ni",16'h220B); add_name("prod",16'h220F);
    add_name("sum",16'h2211); add_name("minus",16'h2212); add_name("lowast",16'h2217);
    add_name("radic",16'h221A); add_name("prop",16'h221D); add_name("infin",16'h221E);
    add_name("ang",16'h2220); add_name("and",16'h2227); add_name("or",16'h2228);
    add_name("cap",16'h2229); add_name("cup",16'h222A); add_name("int",16'h222B);
    add_name("there4",16'h2234); add_name("sim",16'h223C); add_name("cong",16'h2245);
    add_name("asymp",16'h2248); add_name("ne",16'h2260); add_name("equiv",16'h2261);
    add_name("le",16'h2264); add_name("ge",16'h2265); add_name("sub",16'h2282);
    add_name("sup",16'h2283); add_name("nsub",16'h2284); add_name("sube",16'h2286);
    add_name("supe",16'h2287); add_name("oplus",16'h2295); add_name("otimes",16'h2297);
    add_name("perp",16'h22A5); add_name("sdot",16'h22C5); add_name("lceil",16'h2308);
    add_name("rceil",16'h2309); add_name("lfloor",16'h230A); add_name("rfloor",16'h230B);
    add_name("lang",16'h2329); add_name("rang",16'h232A); add_name("loz",16'h25CA);
    add_name("spades",16'h2660); add_name("clubs",16'h2663); add_name("hearts",16'h2665);
    add_name("diams",16'h2666); add_name("quot",16'h0022); add_name("amp",16'h0026);
    add_name("lt",16'h003C); add_name("gt",16'h003E); add_name("OElig",16'h0152);
    add_name("oelig",16'h0153); add_name("Scaron",16'h0160); add_name("scaron",16'h0161);
    add_name("Yuml",16'h0178); add_name("circ",16'h02C6); add_name("tilde",16'h02DC);
    add_name("ensp",16'h2002); add_name("emsp",16'h2003); add_name("thinsp",16'h2009);
    add_name("zwnj",16'h200C); add_name("zwj",16'h200D); add_name("lrm",16'h200E);
    add_name("rlm",16'h200F); add_name("ndash",16'h2013); add_name("mdash",16'h2014);
    add_name("lsquo",16'h2018); add_name("rsquo",16'h2019); add_name("sbquo",16'h201A);
    add_name("ldquo",16'h201C); add_name("rdquo",16'h201D); add_name("bdquo",16'h201E);
    add_name("dagger",16'h2020); add_name("Dagger",16'h2021); add_name("permil",16'h2030);
    add_name("lsaquo",16'h2039); add_name("rsaquo",16'h203A); add_name("euro",16'h20AC);
  endfunction

  function automatic bit digit_c(char_t c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alnum_c(char_t c);
    return digit_c(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit hexdig_c(char_t c);
    return digit_c(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] nibble_of(char_t c);
    if (digit_c(c)) return 4'(c - "0");
    if (c >= "a") return 4'(c - "a" + 10);
    return 4'(c - "A" + 10);
  endfunction

  // Decode one accepted character; queue the words it releases and return the
  // last of them (or 0 when it releases none).
  function automatic char_t decode_char(char_t c, logic fin);
    char_t w [$];
    int    n;
    string nm;
    bit    fail;
    fail = 0;
    case (phase)
      PS_AMP: begin
        if (c == hed_pkg::CH_HASH) begin
          held[held_cnt++] = c; phase = PS_HASH;
        end else if (alnum_c(c)) begin
          held[held_cnt++] = c; phase = PS_NAME;
        end else fail = 1;
      end
      PS_HASH: begin
        if (c == hed_pkg::CH_X) begin
          held[held_cnt++] = c; num_val = 0; phase = PS_HEX;
        end else if (digit_c(c)) begin
          held[held_cnt++] = c; num_val = 32'(c - "0"); phase = PS_DEC;
        end else fail = 1;
      end
      PS_HEX, PS_DEC: begin
        n = held_cnt - ((phase == PS_HEX) ? 3 : 2);
        if ((phase == PS_HEX) ? hexdig_c(c) : digit_c(c)) begin
          if (n < NUM_DIGITS_MAX) begin
            held[held_cnt++] = c;
            num_val = (phase == PS_HEX) ? {num_val[27:0], nibble_of(c)}
                                        : num_val * 10 + 32'(c - "0");
          end else fail = 1;
        end else if (c == hed_pkg::CH_SEMI && n > 0) begin
          w.push_back(num_val[15:0]); held_cnt = 0; phase = PS_IDLE;
        end else fail = 1;
      end
      PS_NAME: begin
        n = held_cnt - 1;
        if (alnum_c(c)) begin
          if (n < NAME_MAX) held[held_cnt++] = c;
          else fail = 1;
        end else if (c == hed_pkg::CH_SEMI && n >= NAME_MIN) begin
          nm = "";
          for (int i = 1; i <= n; i++) nm = $sformatf("%s%c", nm, held[i][7:0]);
          if (entity_code.exists(nm)) begin
            w.push_back(entity_code[nm]); held_cnt = 0; phase = PS_IDLE;
          end else fail = 1;
        end else fail = 1;
      end
      default: begin
        held_cnt = 0;
        if (c == hed_pkg::CH_AMP) begin
          held[held_cnt++] = c; phase = PS_AMP;
        end else w.push_back(c);
      end
    endcase
    // failed run: replay the held words, then restart on '&' or pass the char
    if (fail) begin
      for (int i = 0; i < held_cnt; i++) w.push_back(held[i]);
      held_cnt = 0;
      if (c == hed_pkg::CH_AMP) begin
        held[held_cnt++] = c; phase = PS_AMP;
      end else begin
        w.push_back(c); phase = PS_IDLE;
      end
    end
    // end of text: flush whatever is still held
    if (fin) begin
      for (int i = 0; i < held_cnt; i++) w.push_back(held[i]);
      held_cnt = 0; phase = PS_IDLE; num_val = 0;
    end
    foreach (w[k]) begin
      pending_words.push_back('{w[k], k == w.size() - 1, fin && k == w.size() - 1});
    end
    return (w.size() > 0) ? w[w.size() - 1] : '0;
  endfunction

  // Stimulus builders
  function automatic void put_ch(char_t c, bit typed = 0, char_t want = '0);
    stim_q.push_back('{c, 1'b0, typed, want});
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put_ch(char_t'(s[i]));
  endfunction

  function automatic char_t rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return char_t'("0" + r);
    if (r < 36) return char_t'("A" + r - 10);
    return char_t'("a" + r - 36);
  endfunction

  function automatic char_t rand_hexdig();
    string hx;
    hx = "0123456789abcdefABCDEF";
    return char_t'(hx[$urandom_range(0, 21)]);
  endfunction

  function automatic void add_random_run();
    int n;
    string s;
    case ($urandom_range(0, 10))
      0, 1: begin
        n = $urandom_range(1, 6);
        repeat (n) put_ch($urandom_range(0, 1) ? char_t'($urandom_range(0, 16'hFFFF))
                                               : char_t'($urandom_range(32, 126)));
      end
      2, 3: begin
        put_ch(hed_pkg::CH_AMP);
        put_str(entity_names[$urandom_range(0, entity_names.size() - 1)]);
        put_ch(hed_pkg::CH_SEMI);
      end
      4: begin
        put_str("&#");
        repeat ($urandom_range(1, NUM_DIGITS_MAX + 1)) put_ch(char_t'("0" + $urandom_range(0, 9)));
        put_ch(hed_pkg::CH_SEMI);
      end
      5: begin
        put_str("&#x");
        repeat ($urandom_range(1, NUM_DIGITS_MAX + 1)) put_ch(rand_hexdig());
        put_ch(hed_pkg::CH_SEMI);
      end
      6: begin
        put_ch(hed_pkg::CH_AMP);
        repeat ($urandom_range(1, NAME_MAX + 2)) put_ch(rand_alnum());
        put_ch($urandom_range(0, 3) ? hed_pkg::CH_SEMI : char_t'(" "));
      end
      7: begin
        case ($urandom_range(0, 3))
          0: put_str("&#;");
          1: put_str("&#x;");
          2: put_str("&;");
          default: put_str("&#X41;");
        endcase
      end
      8: begin
        if ($urandom_range(0, 1)) put_str("&&amp;");
        else put_str("&#1&#x4&am&lt;");
      end
      9: begin
        s = "&#x;0a";
        repeat ($urandom_range(1, 5)) put_ch(char_t'(s[$urandom_range(0, 5)]));
      end
      default: begin
        put_ch(hed_pkg::CH_AMP);
        s = entity_names[$urandom_range(0, entity_names.size() - 1)];
        put_str(s.substr(0, $urandom_range(0, s.len() - 1)));
        put_ch($urandom_range(0, 1) ? char_t'(" ") : char_t'(16'hFFFF));
      end
    endcase
    if ($urandom_range(0, 24) == 0) stim_q[stim_q.size() - 1].fin = 1'b1;
  endfunction

  // Directed table: known answers on the word that closes each reference
  function automatic void build_directed();
    put_ch(16'h0000, 1, 16'h0000);
    put_str("&lt"); put_ch(hed_pkg::CH_SEMI, 1, 16'h003C);
    put_str("&#0"); put_ch(hed_pkg::CH_SEMI, 1, 16'h0000);
    put_str("&#x1F600"); put_ch(hed_pkg::CH_SEMI, 1, 16'hF600);
    put_str("&#"); put_ch("X", 1, 16'h0058);
    put_ch(hed_pkg::CH_AMP); put_ch(hed_pkg::CH_SEMI, 1, hed_pkg::CH_SEMI);
    put_str("&#;");
    put_ch(16'hFFFF, 1, 16'hFFFF);
    stim_q[stim_q.size() - 1].fin = 1'b1;
  endfunction

  // Reset
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Sender: bursts with random gaps, one long backlog, two full drain pauses
  initial begin
    int burst_left;
    char_t last_w;
    load_names();
    phase = PS_IDLE; held_cnt = 0; num_val = 0;
    build_directed();
    directed_len = stim_q.size();
    while (stim_q.size() < ITEM_GOAL) add_random_run();
    stim_q[stim_q.size() - 1].fin = 1'b1;
    burst_left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    foreach (stim_q[i]) begin
      if (i == directed_len || i == 220) begin
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
      end else if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 30);
      end
      if (i == 120) hold_req = 1;
      if (burst_left > 0) burst_left--;
      in_valid <= 1'b1;
      in_char <= stim_q[i].ch;
      in_text_end <= stim_q[i].fin;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      last_w = decode_char(stim_q[i].ch, stim_q[i].fin);
      if (stim_q[i].fin) texts_seen++;
      if (stim_q[i].typed && last_w !== stim_q[i].want) begin
        errs++;
        if (errs <= 10)
          $display("directed row %0d: expected %h, model gives %h", i, stim_q[i].want, last_w);
      end
    end
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb_top: %0d characters in %0d texts, %0d words out, long output stall done",
             stim_q.size(), texts_seen, words_seen);
    if (errs == 0 && !timed_out) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Receiver: windows of steady, even and sparse ready, plus one long hold
  initial begin
    int mode;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        mode = $urandom_range(0, 2);
        repeat (16) begin
          out_ready <= (mode == 0) ? 1'b1 :
                       (mode == 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 3) == 0);
          @(posedge clk);
        end
      end
    end
  end

  // Check each accepted word against the oldest expectation
  always @(posedge clk) begin
    word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected word %h", out_char);
      end else begin
        exp_w = pending_words.pop_front();
        if (out_char !== exp_w.ch || out_run_last !== exp_w.last ||
            out_text_done !== exp_w.done) begin
          errs++;
          if (errs <= 10)
            $display("word %0d: expected %h/%b/%b, got %h/%b/%b", words_seen,
                     exp_w.ch, exp_w.last, exp_w.done, out_char, out_run_last, out_text_done);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #3ms;
    timed_out = 1;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
